// ----- src/epq_pkg.sv -----
// Shared types and constants for the event priority queue.
package epq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic [7:0]         prio;
    logic [7:0]         sys;
    logic [7:0]         res;
    logic [7:0]         stat;
    logic signed [15:0] amt;
  } record_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         priority_req;
    logic [7:0]         system_tag;
    logic [7:0]         resource_tag;
    logic [7:0]         status;
    logic signed [15:0] amount;
  } epq_in_t;

  typedef struct packed {
    logic               popped;
    logic [7:0]         out_priority;
    logic [7:0]         out_system_tag;
    logic [7:0]         out_resource_tag;
    logic [7:0]         out_status;
    logic signed [15:0] out_amount;
    logic               dropped;
    logic [OCC_W-1:0]   occupancy;
  } epq_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- src/epq_cell.sv -----
// One slot of the sorted shift chain: holds a record, shifts on push or pop.
module epq_cell (
  input  logic              clk,
  input  epq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  epq_pkg::record_t  new_rec,
  input  logic              left_gt,
  input  epq_pkg::record_t  left_rec,
  input  epq_pkg::record_t  right_rec,
  output logic              gt,
  output epq_pkg::record_t  rec
);
  import epq_pkg::*;

  record_t rec_next;

  // Stored record outranks the incoming one; these bits form a prefix.
  assign gt = valid && (rec.prio > new_rec.prio);

  always_comb begin
    rec_next = rec;
    if (ctl.push) begin
      if (!gt) begin
        rec_next = left_gt ? new_rec : left_rec;
      end
    end else if (ctl.pop) begin
      rec_next = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ----- src/event_priority_queue.sv -----
// Top level of the event priority queue: cell chain, count and result register.
//
//   channel   direction  handshake             payload
//   item      in         start & !busy         epq_in_t
//   result    out        done (one cycle)      epq_out_t
//
// Each item's result is registered and shows in the cycle after accept.
// busy stays low, so an item can be taken on every cycle.
// Every cell compares and shifts at once; the priority compare across the
// chain sets the cycle. Synchronous reset empties the count and clears done.
// The receiver cannot stall: each result is valid for done's single cycle.
module event_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  epq_pkg::epq_in_t item,
  output logic             done,
  output epq_pkg::epq_out_t result
);
  import epq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  record_t          new_rec;
  record_t          cell_rec [DEPTH];
  logic             cell_gt  [DEPTH];
  epq_out_t         result_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  assign new_rec = '{prio: item.priority_req, sys: item.system_tag,
                     res: item.resource_tag, stat: item.status, amt: item.amount};

  assign ctl.push = accept && (item.cmd == CMD_PUSH) && !full;
  assign ctl.pop  = accept && (item.cmd == CMD_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    epq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CNT_W'(i) < count),
      .new_rec   (new_rec),
      .left_gt   ((i == 0) ? 1'b1 : cell_gt[(i == 0) ? 0 : i - 1]),
      .left_rec  (cell_rec[(i == 0) ? 0 : i - 1]),
      .right_rec (cell_rec[(i == DEPTH - 1) ? i : i + 1]),
      .gt        (cell_gt[i]),
      .rec       (cell_rec[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    result_next = '0;
    result_next.occupancy = OCC_W'(count_next);
    if (accept && (item.cmd == CMD_PUSH)) begin
      result_next.dropped = full;
    end else if (ctl.pop) begin
      result_next.popped           = 1'b1;
      result_next.out_priority     = cell_rec[0].prio;
      result_next.out_system_tag   = cell_rec[0].sys;
      result_next.out_resource_tag = cell_rec[0].res;
      result_next.out_status       = cell_rec[0].stat;
      result_next.out_amount       = cell_rec[0].amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

// ----- test/event_priority_queue_tb.sv -----
// Self-checking testbench for the event priority queue: directed and random push/pop beats.
module event_priority_queue_tb;
  import epq_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_CYCLES  = 8;

  // Holds its own copy of the sorted store and the results it predicts from it.
  class sorted_store_checker;
    record_t  held[$];
    epq_out_t awaited[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    function void note_item(input epq_in_t it);
      epq_out_t exp_res;
      record_t  rec;
      int       pos;
      exp_res = '0;
      if (it.cmd == CMD_PUSH) begin
        if (held.size() >= DEPTH) begin
          exp_res.dropped = 1'b1;
        end else begin
          rec.prio = it.priority_req;
          rec.sys  = it.system_tag;
          rec.res  = it.resource_tag;
          rec.stat = it.status;
          rec.amt  = it.amount;
          // new record goes ahead of the first one with priority <= its own
          pos = 0;
          while (pos < held.size() && held[pos].prio > rec.prio) pos++;
          held.insert(pos, rec);
        end
      end else if (held.size() > 0) begin
        rec = held.pop_front();
        exp_res.popped           = 1'b1;
        exp_res.out_priority     = rec.prio;
        exp_res.out_system_tag   = rec.sys;
        exp_res.out_resource_tag = rec.res;
        exp_res.out_status       = rec.stat;
        exp_res.out_amount       = rec.amt;
      end
      exp_res.occupancy = OCC_W'(held.size());
      awaited.push_back(exp_res);
    endfunction

    task check_result(input epq_out_t got);
      epq_out_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing awaited, occupancy", int'(got.occupancy), -1);
      end else begin
        want = awaited.pop_front();
        if (got.popped !== want.popped)
          report_mismatch("popped", int'(got.popped), int'(want.popped));
        if (got.out_priority !== want.out_priority)
          report_mismatch("out_priority", int'(got.out_priority), int'(want.out_priority));
        if (got.out_system_tag !== want.out_system_tag)
          report_mismatch("out_system_tag", int'(got.out_system_tag),
                          int'(want.out_system_tag));
        if (got.out_resource_tag !== want.out_resource_tag)
          report_mismatch("out_resource_tag", int'(got.out_resource_tag),
                          int'(want.out_resource_tag));
        if (got.out_status !== want.out_status)
          report_mismatch("out_status", int'(got.out_status), int'(want.out_status));
        if (got.out_amount !== want.out_amount)
          report_mismatch("out_amount", int'(got.out_amount), int'(want.out_amount));
        if (got.dropped !== want.dropped)
          report_mismatch("dropped", int'(got.dropped), int'(want.dropped));
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", int'(got.occupancy), int'(want.occupancy));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  epq_in_t  item = '0;
  logic     done;
  epq_out_t result;

  sorted_store_checker sb = new();
  int idle_pct = 38;
  int cycle_count = 0;

  event_priority_queue dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample on the edge: result before noting, since results trail the accept.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
    if (!rst && start && !busy) sb.note_item(item);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic epq_in_t noise_item();
    epq_in_t     it;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    it   = bits[$bits(epq_in_t)-1:0];
    return it;
  endfunction

  task automatic send_item(input epq_in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      item  <= noise_item();
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_rec(input logic [7:0] prio, input logic [7:0] sys,
                          input logic [7:0] res, input logic [7:0] stat,
                          input logic signed [15:0] amt);
    epq_in_t it;
    it.cmd          = CMD_PUSH;
    it.priority_req = prio;
    it.system_tag   = sys;
    it.resource_tag = res;
    it.status       = stat;
    it.amount       = amt;
    send_item(it);
  endtask

  task automatic pop_rec();
    epq_in_t it;
    it     = noise_item();
    it.cmd = CMD_POP;
    send_item(it);
  endtask

  // Random beat; tie mode draws priorities from a few values so equal keys pile up.
  function automatic epq_in_t random_item(input int push_pct, input bit tie_mode);
    epq_in_t it;
    it     = noise_item();
    it.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
    if (tie_mode) begin
      case ($urandom_range(0, 3))
        0: it.priority_req = 8'd0;
        1: it.priority_req = 8'd64;
        2: it.priority_req = 8'd128;
        default: it.priority_req = 8'd255;
      endcase
    end
    return it;
  endfunction

  initial begin
    int push_pct;
    bit tie_mode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, field extremes, equal-priority order, fill and overflow
    pop_rec();
    push_rec(8'd0, 8'd0, 8'd0, 8'd0, -16'sd32768);
    push_rec(8'd255, 8'd255, 8'd255, 8'd255, 16'sd32767);
    push_rec(8'd128, 8'h5a, 8'ha5, 8'h0f, 16'sd0);
    push_rec(8'd128, 8'ha5, 8'h5a, 8'hf0, -16'sd1);
    pop_rec();
    pop_rec();
    pop_rec();
    pop_rec();
    for (int i = 0; i < DEPTH; i++)
      push_rec(8'((i % 5) * 60), 8'(i), 8'(255 - i), 8'(i * 16), 16'((i * 4099) - 32768));
    push_rec(8'd200, 8'd1, 8'd2, 8'd3, 16'sd4);

    // hold off until everything directed has come back
    start <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);

    push_pct = 50;
    tie_mode = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 85;
          1: push_pct = 20;
          2: push_pct = 50;
          3: push_pct = 97;
          default: push_pct = 5;
        endcase
        tie_mode = 1'($urandom_range(0, 1));
      end
      idle_pct = (n >= 400 && n < 650) ? 0 : 38;
      send_item(random_item(push_pct, tie_mode));
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report_mismatch("results still awaited", 0, sb.awaited.size());

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/epq_pkg.sv
src/epq_cell.sv
src/event_priority_queue.sv
test/event_priority_queue_tb.sv
